// ===== design/spq_pkg.sv =====
package spq_pkg;

	// Operation carried in the input tuser
	typedef enum logic [0:0] {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} spq_cmd_t;

	// Result status carried in the output tuser
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	// Operation broadcast from the control to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
	} spq_op_t;

	localparam int unsigned FIELD_W    = 8;
	localparam int unsigned CAP_W      = 5;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned IN_USER_W  = 1;
	localparam int unsigned OUT_DATA_W = 24;
	localparam int unsigned OUT_USER_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

// ===== design/spq_cell.sv =====
module spq_cell #(
	parameter int unsigned PW = 8
) (
	input  logic                            clk,
	input  spq_pkg::spq_op_t                op,
	input  logic                            occupied,
	input  logic [PW-1:0]                   new_prio,
	input  logic [spq_pkg::FIELD_W-1:0]     new_info,
	input  logic                            left_ge,
	input  logic [PW-1:0]                   left_prio,
	input  logic [spq_pkg::FIELD_W-1:0]     left_info,
	input  logic [PW-1:0]                   right_prio,
	input  logic [spq_pkg::FIELD_W-1:0]     right_info,
	output logic                            ge,
	output logic [PW-1:0]                   prio,
	output logic [spq_pkg::FIELD_W-1:0]     info
);

	import spq_pkg::*;

	logic [PW-1:0]      prio_q;
	logic [FIELD_W-1:0] info_q;

	// This slot stays ahead of the new entry when it holds an equal or higher priority
	assign ge = occupied && (prio_q >= new_prio);

	// Insert: keep, take the new entry at the boundary, or shift in from the left.
	// Remove: shift in from the right. Otherwise hold.
	always_ff @(posedge clk) begin
		priority if (op.ins && !ge) begin
			if (left_ge) begin
				prio_q <= new_prio;
				info_q <= new_info;
			end else begin
				prio_q <= left_prio;
				info_q <= left_info;
			end
		end else if (op.del) begin
			prio_q <= right_prio;
			info_q <= right_info;
		end else begin
			prio_q <= prio_q;
			info_q <= info_q;
		end
	end

	assign prio = prio_q;
	assign info = info_q;

endmodule

// ===== design/sorted_priority_queue_unit.sv =====
// Channel  | Dir | Handshake              | Payload (lowest bit first)
// s_axis   | in  | s_axis_tvalid/tready   | tdata: entry_priority, entry_info; tuser: cmd
// m_axis   | out | m_axis_tvalid/tready   | tdata: out_priority, out_info, count, is_empty,
//          |     |                        |   is_full, zero pad; tuser: status
// cfg      | in  | cfg_valid/cfg_ready    | cfg_data: capacity
//
// One transaction per cycle while no finished result is held back: every cell of the
// row compares its priority with the incoming one in parallel and shifts in the same
// edge, so the result sits in the output register the cycle after the input is taken.
// Reset clears the count and the result valid flag and sets capacity to 16; cell
// contents are not reset and are never read beyond the count.
// s_axis_tready drops only while a finished result waits and m_axis_tready is low.
module sorted_priority_queue_unit #(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned PRIO_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// entry_priority [7:0], entry_info [15:8]
	input  logic [spq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// cmd [0]
	input  logic [spq_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// out_priority [7:0], out_info [15:8], count [20:16], is_empty [21], is_full [22]
	output logic [spq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// status [1:0]
	output logic [spq_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [spq_pkg::CAP_W-1:0]          cfg_data
);

	import spq_pkg::*;

	localparam int unsigned PW    = (PRIO_BITS < FIELD_W) ? PRIO_BITS : FIELD_W;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0]      cap_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	logic                  accept;
	spq_cmd_t              cmd;
	logic [PW-1:0]         new_prio;
	logic [FIELD_W-1:0]    new_info;
	logic [CMP_W-1:0]      cap_eff;
	logic                  full_now;
	logic                  empty_now;
	spq_op_t               op;
	spq_status_t           status;
	logic [FIELD_W-1:0]    res_prio;
	logic [FIELD_W-1:0]    res_info;

	logic                  ge_w   [DEPTH];
	logic [PW-1:0]         prio_w [DEPTH];
	logic [FIELD_W-1:0]    info_w [DEPTH];

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// Input unpacking
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign cmd      = spq_cmd_t'(s_axis_tuser[0]);
	assign new_prio = PW'(s_axis_tdata[FIELD_W-1:0]);
	assign new_info = s_axis_tdata[2*FIELD_W-1:FIELD_W];

	// Clamp capacity into 1..DEPTH
	always_comb begin
		cap_eff = CMP_W'(cap_q);
		if (cap_eff == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_eff > CMP_W'(DEPTH)) begin
			cap_eff = CMP_W'(DEPTH);
		end
	end

	assign full_now  = CMP_W'(count_q) >= cap_eff;
	assign empty_now = count_q == '0;

	// Decide the operation, the status and the next count
	always_comb begin
		op.ins  = 1'b0;
		op.del  = 1'b0;
		status  = ST_OK;
		count_d = count_q;
		unique case (cmd)
			CMD_ENQ: begin
				if (full_now) begin
					status = ST_FULL;
				end else begin
					op.ins  = accept;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_DEQ: begin
				if (empty_now) begin
					status = ST_EMPTY;
				end else begin
					op.del  = accept;
					count_d = count_q - CNT_W'(1);
				end
			end
		endcase
	end

	// Head of the row leaves on a successful dequeue
	assign res_prio = (cmd == CMD_DEQ && !empty_now) ? FIELD_W'(prio_w[0]) : '0;
	assign res_info = (cmd == CMD_DEQ && !empty_now) ? info_w[0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Row of cells, head at index zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                occ;
		logic                l_ge;
		logic [PW-1:0]       l_prio;
		logic [FIELD_W-1:0]  l_info;
		logic [PW-1:0]       r_prio;
		logic [FIELD_W-1:0]  r_info;

		assign occ = count_q > CNT_W'(i);

		if (i == 0) begin : g_head
			assign l_ge   = 1'b1;
			assign l_prio = new_prio;
			assign l_info = new_info;
		end else begin : g_mid
			assign l_ge   = ge_w[i-1];
			assign l_prio = prio_w[i-1];
			assign l_info = info_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_prio = prio_w[i];
			assign r_info = info_w[i];
		end else begin : g_inner
			assign r_prio = prio_w[i+1];
			assign r_info = info_w[i+1];
		end

		spq_cell #(
			.PW (PW)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.occupied   (occ),
			.new_prio   (new_prio),
			.new_info   (new_info),
			.left_ge    (l_ge),
			.left_prio  (l_prio),
			.left_info  (l_info),
			.right_prio (r_prio),
			.right_info (r_info),
			.ge         (ge_w[i]),
			.prio       (prio_w[i]),
			.info       (info_w[i])
		);
	end

	// Output register: accept a new transaction while it is empty or the held one is taken
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {
				1'b0,
				CMP_W'(count_d) >= cap_eff,
				count_d == '0,
				CAP_W'(count_d),
				res_info,
				res_prio
			};
			out_user_q <= status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule
